// ===== sv/assert_macros.svh =====
// Assertion macros for the checker of the text cell renderer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MTCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MTCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mtcr_pkg.sv =====
// Types and constants shared by the text cell renderer modules.
package mtcr_pkg;

	localparam logic [1:0] REQ_CELL  = 2'd0;
	localparam logic [1:0] REQ_VSYNC = 2'd1;
	localparam logic [1:0] REQ_FONT  = 2'd2;

	localparam logic REG_VIDEO_ENABLE = 1'b0;
	localparam logic REG_BLINK_ENABLE = 1'b1;

	localparam int FONT_ADDR_W = 12;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef logic [1:0] pen_t;

	localparam pen_t PEN_OFF    = 2'd0;
	localparam pen_t PEN_NORMAL = 2'd2;
	localparam pen_t PEN_BRIGHT = 2'd3;

	// One classified item on its way from the front end to the back end.
	typedef struct packed {
		logic                   is_write;
		logic [FONT_ADDR_W-1:0] addr;
		logic [7:0]             wdata;
		pen_t                   fg;
		pen_t                   bg;
		logic                   force_ff;
		logic                   force_zero;
		logic                   dup;
		logic                   row_done;
	} queue_entry_t;

endpackage

// ===== sv/mtcr_front.sv =====
// Front end: accepts items, keeps the frame counter and classifies cells and font writes.
module mtcr_front import mtcr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [1:0]   req_type,
	input  logic [7:0]   char_code,
	input  logic [7:0]   attribute,
	input  logic [4:0]   row_in_cell,
	input  logic         cursor_here,
	input  logic         end_of_row,
	input  logic         vsync_level,
	input  logic [11:0]  font_addr,
	input  logic [7:0]   font_data,
	input  logic         video_enable,
	input  logic         blink_enable,
	input  logic         queue_full,
	output logic         in_stall,
	output logic         push,
	output queue_entry_t push_entry
);

	logic [4:0]             frame_count_q;
	logic                   accept;
	logic [FONT_ADDR_W-1:0] row_offset;
	pen_t                   fg;
	pen_t                   bg;
	logic                   underline;
	logic                   blink_off;
	logic                   cursor_on;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= 5'd0;
		end else if (accept && req_type == REQ_VSYNC) begin
			frame_count_q <= frame_count_q + {4'd0, vsync_level};
		end
	end

	// Rows with bit 3 set come from the upper half of the font.
	always_comb begin
		if (row_in_cell[3]) begin
			row_offset = {1'b1, 8'd0, row_in_cell[2:0]};
		end else begin
			row_offset = {7'd0, row_in_cell};
		end
	end

	always_comb begin
		case (attribute)
			8'h00, 8'h08, 8'h80, 8'h88: begin
				fg = PEN_OFF;
				bg = PEN_OFF;
			end
			8'h70, 8'h78: begin
				fg = PEN_OFF;
				bg = PEN_NORMAL;
			end
			8'hf0, 8'hf8: begin
				fg = PEN_OFF;
				bg = blink_enable ? PEN_NORMAL : PEN_BRIGHT;
			end
			default: begin
				fg = attribute[3] ? PEN_BRIGHT : PEN_NORMAL;
				bg = PEN_OFF;
			end
		endcase
	end

	assign underline = (row_in_cell == 5'd12) && (attribute[2:0] == 3'd1);
	assign blink_off = frame_count_q[4] && blink_enable && attribute[7];
	assign cursor_on = cursor_here && frame_count_q[3];

	always_comb begin
		push_entry.is_write   = (req_type == REQ_FONT);
		push_entry.addr       = (req_type == REQ_FONT) ? font_addr
		                        : ({1'b0, char_code, 3'd0} + row_offset);
		push_entry.wdata      = font_data;
		push_entry.fg         = fg;
		push_entry.bg         = bg;
		push_entry.force_ff   = cursor_on || (underline && !blink_off);
		push_entry.force_zero = blink_off && !cursor_on;
		push_entry.dup        = (char_code[7:5] == 3'b110) || underline || cursor_on;
		push_entry.row_done   = end_of_row;
	end

	// Vsync items, unknown kinds and cells with video off stop here.
	assign push = accept && ((req_type == REQ_FONT) || (req_type == REQ_CELL && video_enable));

endmodule

// ===== sv/mtcr_queue.sv =====
// Short queue of classified items between the front end and the back end.
module mtcr_queue import mtcr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  queue_entry_t push_entry,
	input  logic         pop,
	output logic         full,
	output logic         not_empty,
	output queue_entry_t head
);

	queue_entry_t            entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/mtcr_back.sv =====
// Back end: font store, font read stage and pen expansion into the output register.
module mtcr_back import mtcr_pkg::*; #(
	parameter int FONT_DEPTH = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_not_empty,
	input  queue_entry_t q_head,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [17:0]  pens,
	output logic         row_done
);

	localparam int AW = $clog2(FONT_DEPTH);

	logic [7:0]   font_mem [FONT_DEPTH];
	logic         valid_s1;
	queue_entry_t ent_s1;
	logic [7:0]   rd_data_s1;
	logic         out_valid_q;
	logic [17:0]  pens_q;
	logic         row_done_q;
	logic         out_ready;
	logic         s1_ready;
	logic [AW-1:0] mem_addr;
	logic [7:0]   pix;
	logic [17:0]  pens_next;

	assign out_ready = !out_valid_q || !out_stall;
	assign s1_ready  = !valid_s1 || out_ready;
	assign pop       = q_not_empty && s1_ready;
	assign mem_addr  = AW'(q_head.addr);

	always_ff @(posedge clk) begin
		if (pop && q_head.is_write) begin
			font_mem[mem_addr] <= q_head.wdata;
		end
		if (pop && !q_head.is_write) begin
			rd_data_s1 <= font_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s1 <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= pop && !q_head.is_write;
		end
	end

	always_comb begin
		if (ent_s1.force_ff) begin
			pix = 8'hff;
		end else if (ent_s1.force_zero) begin
			pix = 8'h00;
		end else begin
			pix = rd_data_s1;
		end
	end

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			pens_next[17 - 2*k -: 2] = pix[7 - k] ? ent_s1.fg : ent_s1.bg;
		end
		pens_next[1:0] = (ent_s1.dup && pix[0]) ? ent_s1.fg : ent_s1.bg;
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s1) begin
			pens_q     <= pens_next;
			row_done_q <= ent_s1.row_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign pens      = pens_q;
	assign row_done  = row_done_q;

endmodule

// ===== sv/mono_text_cell_renderer.sv =====
// Top level of the monochrome text cell renderer: config registers and the three parts.
//
// Usage. One input channel (in_valid / in_stall) carries three kinds of item, picked by
// req_type: a character cell, a vsync event and a font store write. A transfer happens at a
// rising edge with in_valid high and in_stall low. Cells produce one transfer on the output
// channel (out_valid / out_stall) with nine 2-bit pens and the row_done echo; vsync items,
// font writes, unknown kinds and cells while video is disabled produce nothing.
// Throughput is one item per cycle while out_stall is low. A cell's result passes through
// the queue, then the font store read stage, then the output register. The font
// store has one port shared in order by writes and reads, so a font write is seen by every
// cell accepted after it. The user must write configuration (cfg_we / cfg_index / cfg_data)
// only while the block is idle; the block itself does not enforce this.
// When the receiver stalls, the output register holds its result, the read stage fills, and
// the four-entry queue absorbs further items; in_stall rises only when that queue is full.
// Reset clears the config registers, the frame counter, the queue and all valid flags. The
// font store is not cleared and must be loaded before cells read it.
module mono_text_cell_renderer import mtcr_pkg::*; #(
	parameter int FONT_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attribute,
	input  logic [4:0]  row_in_cell,
	input  logic        cursor_here,
	input  logic        end_of_row,
	input  logic        vsync_level,
	input  logic [11:0] font_addr,
	input  logic [7:0]  font_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [17:0] pens,
	output logic        row_done
);

	logic         video_enable_q;
	logic         blink_enable_q;
	logic         push;
	logic         pop;
	logic         queue_full;
	logic         queue_not_empty;
	queue_entry_t push_entry;
	queue_entry_t queue_head;

	// Mode bits. Index 0 enables video, index 1 enables attribute blink.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_enable_q <= 1'b0;
			blink_enable_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VIDEO_ENABLE: video_enable_q <= cfg_data;
				REG_BLINK_ENABLE: blink_enable_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end owns the frame counter, so every cell sees the count left by
	// the vsync items accepted before it.
	mtcr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.req_type     (req_type),
		.char_code    (char_code),
		.attribute    (attribute),
		.row_in_cell  (row_in_cell),
		.cursor_here  (cursor_here),
		.end_of_row   (end_of_row),
		.vsync_level  (vsync_level),
		.font_addr    (font_addr),
		.font_data    (font_data),
		.video_enable (video_enable_q),
		.blink_enable (blink_enable_q),
		.queue_full   (queue_full),
		.in_stall     (in_stall),
		.push         (push),
		.push_entry   (push_entry)
	);

	mtcr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (queue_full),
		.not_empty  (queue_not_empty),
		.head       (queue_head)
	);

	mtcr_back #(
		.FONT_DEPTH (FONT_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (queue_not_empty),
		.q_head      (queue_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pens        (pens),
		.row_done    (row_done)
	);

endmodule

// ===== sv/mtcr_checker.sv =====
// Port-level checker for the text cell renderer and its bind to the top level.
`include "assert_macros.svh"

module mtcr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [17:0] pens,
	input logic        row_done
);

	// A stalled result stays offered and unchanged.
	`MTCR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(pens) && $stable(row_done), "stalled result changed")

	// The input side only fills up while the receiver holds off a waiting result.
	`MTCR_ASSERT_NOW(a_stall_cause, clk, arst_n, $rose(in_stall), $past(out_valid && out_stall), "input stall without output backpressure")

	// Once the receiver takes results again, a full queue pops an entry and in_stall falls.
	`MTCR_ASSERT_NEXT(a_stall_release, clk, arst_n, in_stall && !out_stall, !in_stall, "input stall held without backpressure")

endmodule

bind mono_text_cell_renderer mtcr_checker u_mtcr_checker (.*);
